/* rtl/core/jeo_pkg.sv */
// Package for the Josephus elimination order block.
// Holds the request and result beat types and the sequencer state type.
// Depends on nothing; used by the top level and the testbench.
package jeo_pkg;

  // Field widths of the request and result beats.
  localparam int PeopleW = 7;
  localparam int StepW   = 10;
  localparam int PersonW = 7;

  // One request beat: circle size and step count.
  typedef struct packed {
    logic [PeopleW-1:0] people;
    logic [StepW-1:0]   step;
  } jeo_req_t;

  // One result beat: removed person or survivor, with the final marker.
  typedef struct packed {
    logic [PersonW-1:0] person;
    logic               last;
  } jeo_res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_CHECK,
    ST_HOP,
    ST_LINK
  } jeo_state_e;

endpackage

/* rtl/core/jeo_ring_mem.sv */
// Next-pointer memory of the ring: one write port and one registered read port.
// Depends on nothing; instantiated by josephus_elimination_order_top.
module jeo_ring_mem #(
  parameter  int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [AddrW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [AddrW-1:0] rdata_o
);

  logic [AddrW-1:0] mem_q [Depth];
  logic [AddrW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/josephus_elimination_order_top.sv */
// Top level of the Josephus elimination order block: sequencer and pointer datapath.
// Depends on jeo_pkg and jeo_ring_mem.
//
//   Channel   Ports                              Beat moves when
//   request   start, busy, req_i (jeo_req_t)     start high and busy low at a clock edge
//   result    result_valid_o, res_o (jeo_res_t)  result_valid_o high
//
// A request of n people and step m builds the ring in ST_FILL; then for each of the
// n - 1 removals it hops m - 1 times (none for step 0) via ST_CHECK and ST_HOP, and
// unlinks via ST_CHECK and ST_LINK; last comes the survivor. Each hop waits for the
// ring memory's registered read. A circle of zero people is taken and gives no beat.
// Reset clears the sequencer; the ring memory is rewritten by every non-empty request.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module josephus_elimination_order_top #(
  parameter int MAX_PEOPLE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  jeo_pkg::jeo_req_t req_i,
  output logic              result_valid_o,
  output jeo_pkg::jeo_res_t res_o
);

  localparam int IdxW = $clog2(MAX_PEOPLE);
  localparam int CntW = $clog2(MAX_PEOPLE + 1);
  localparam int ExtW = (CntW > jeo_pkg::PeopleW) ? CntW : jeo_pkg::PeopleW;

  jeo_pkg::jeo_state_e state_q, state_d;

  logic [IdxW-1:0]             cur_q, cur_d;
  logic [IdxW-1:0]             prev_q, prev_d;
  logic [IdxW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             rem_q, rem_d;
  logic [jeo_pkg::StepW-1:0]   step_q, step_d;
  logic [jeo_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic                        res_valid_q, res_valid_d;
  jeo_pkg::jeo_res_t           res_q, res_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_wdata;
  logic [IdxW-1:0] mem_rdata;

  logic [ExtW-1:0] people_ext;
  logic [CntW-1:0] n_sat;
  logic [IdxW:0]   cur_plus;

  // Saturate the circle size to the ring depth.
  assign people_ext = ExtW'(req_i.people);
  assign n_sat = (people_ext > ExtW'(MAX_PEOPLE)) ? CntW'(MAX_PEOPLE) : CntW'(people_ext);

  // One-based number of the person under the pointer.
  assign cur_plus = {1'b0, cur_q} + 1'b1;

  jeo_ring_mem #(
    .Depth(MAX_PEOPLE)
  ) u_ring_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(cur_q),
    .rdata_o(mem_rdata)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jeo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      prev_q      <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      rem_q       <= rem_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  // Next state, datapath updates and memory commands.
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_q;
    mem_wdata   = fill_q + 1'b1;

    case (state_q)
      jeo_pkg::ST_IDLE: begin
        if (start) begin
          if (n_sat == '0) begin
            rem_d = '0;
          end else begin
            cur_d   = '0;
            prev_d  = IdxW'(n_sat - 1'b1);
            rem_d   = n_sat;
            fill_d  = '0;
            step_d  = req_i.step;
            cnt_d   = jeo_pkg::StepW'(1);
            state_d = jeo_pkg::ST_FILL;
          end
        end
      end

      // Build the ring one entry per cycle; prev_q holds the last index.
      jeo_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (fill_q == prev_q) begin
          mem_wdata = '0;
          state_d   = jeo_pkg::ST_CHECK;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end

      // Decide between a hop, a removal and the survivor.
      jeo_pkg::ST_CHECK: begin
        if (rem_q <= CntW'(1)) begin
          prev_d      = cur_q;
          res_valid_d = 1'b1;
          res_d.person = jeo_pkg::PersonW'(cur_plus);
          res_d.last   = 1'b1;
          state_d     = jeo_pkg::ST_IDLE;
        end else if (cnt_q < step_q) begin
          state_d = jeo_pkg::ST_HOP;
        end else begin
          res_valid_d  = 1'b1;
          res_d.person = jeo_pkg::PersonW'(cur_plus);
          res_d.last   = 1'b0;
          state_d      = jeo_pkg::ST_LINK;
        end
      end

      // Read data holds the successor of the counted person.
      jeo_pkg::ST_HOP: begin
        prev_d  = cur_q;
        cur_d   = mem_rdata;
        cnt_d   = cnt_q + 1'b1;
        state_d = jeo_pkg::ST_CHECK;
      end

      // Unlink the removed person and count on from its successor.
      jeo_pkg::ST_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = prev_q;
        mem_wdata = mem_rdata;
        cur_d     = mem_rdata;
        rem_d     = rem_q - 1'b1;
        cnt_d     = jeo_pkg::StepW'(1);
        state_d   = jeo_pkg::ST_CHECK;
      end

      default: begin
        state_d = jeo_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != jeo_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  // The survivor beat ends the request.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |-> (state_q == jeo_pkg::ST_IDLE))
    else $error("survivor shown while the sequencer is still working");

  // A removal only happens while at least two people remain.
  a_link_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jeo_pkg::ST_LINK) |-> (rem_q > CntW'(1)))
    else $error("removal with fewer than two people left");

  // A hop is only taken while the count is short of the step.
  a_hop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jeo_pkg::ST_HOP) |-> (cnt_q < step_q))
    else $error("hop beyond the step count");

  // A non-empty request starts the ring build.
  a_start_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.people != '0)) |=> (state_q == jeo_pkg::ST_FILL))
    else $error("accepted request did not start the ring build");

endmodule

/* tb/josephus_elimination_order_top_test.sv */
// Testbench for josephus_elimination_order_top: directed stimulus table, then random requests.
// Every result beat is checked against a queue of expected beats; depends on jeo_pkg.
`timescale 1ns / 100ps

module josephus_elimination_order_top_test;

  localparam int MaxPeople   = 64;
  localparam int RandomReqs  = 100;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 200;

  // One row of the directed stimulus.  When in_order is set the expected beats
  // are simply persons 1..n in turn, which holds for a step of 0 or 1, for a
  // circle of one and for an empty circle.
  typedef struct packed {
    logic [jeo_pkg::PeopleW-1:0] people;
    logic [jeo_pkg::StepW-1:0]   step;
    logic                        in_order;
  } stim_row_t;

  localparam int NumRows = 22;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  jeo_pkg::jeo_req_t req_i;
  logic              result_valid_o;
  jeo_pkg::jeo_res_t res_o;

  // Marks the request on the bus as one whose beats are typed in, not predicted.
  logic      req_in_order;

  jeo_pkg::jeo_res_t removals_due[$];
  int                fault_count;
  int                requests_sent;
  stim_row_t         stim_rows [NumRows];

  josephus_elimination_order_top #(
    .MAX_PEOPLE(MaxPeople)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .res_o         (res_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected beats for a request whose order can be read off directly: 1, 2, .. n.
  function automatic void push_in_order(input logic [jeo_pkg::PeopleW-1:0] people);
    int unsigned n;
    n = (32'(people) > MaxPeople) ? MaxPeople : 32'(people);
    for (int unsigned k = 1; k <= n; k++) begin
      removals_due.push_back('{person: jeo_pkg::PersonW'(k), last: (k == n)});
    end
  endfunction

  // Walks the ring of next pointers exactly as the block does and queues every
  // removal in order, then the survivor with the final marker.
  function automatic void predict_elimination(input jeo_pkg::jeo_req_t rq);
    logic [5:0]  link [MaxPeople];
    logic [5:0]  here;
    logic [5:0]  behind;
    int unsigned n;
    int unsigned m;
    int unsigned alive;
    n = 32'(rq.people);
    m = 32'(rq.step);
    if (n == 0) begin
      return;
    end
    if (n > MaxPeople) begin
      n = MaxPeople;
    end
    for (int unsigned i = 0; i < n; i++) begin
      link[i] = (i + 1 == n) ? 6'd0 : 6'(i + 1);
    end
    here   = 6'd0;
    behind = 6'(n - 1);
    alive  = n;
    while (alive > 1) begin
      for (int unsigned hop = 1; hop < m; hop++) begin
        behind = here;
        here   = link[here];
      end
      removals_due.push_back('{person: {1'b0, here} + jeo_pkg::PersonW'(1), last: 1'b0});
      link[behind] = link[here];
      here         = link[behind];
      alive--;
    end
    removals_due.push_back('{person: {1'b0, here} + jeo_pkg::PersonW'(1), last: 1'b1});
  endfunction

  // Result checking and prediction, both on the rising edge.
  always @(posedge clk_i) begin : scoreboard
    jeo_pkg::jeo_res_t want;
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        if (removals_due.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display("%0t: result beat with none expected: person %0d last %0b",
                     $realtime, res_o.person, res_o.last);
          end
        end else begin
          want = removals_due.pop_front();
          if (res_o.person !== want.person || res_o.last !== want.last) begin
            fault_count++;
            if (fault_count <= ReportLimit) begin
              $display("%0t: mismatch: expected person %0d last %0b, got person %0d last %0b",
                       $realtime, want.person, want.last, res_o.person, res_o.last);
            end
          end
        end
      end
      if (start && busy === 1'b0) begin
        if (req_in_order) begin
          push_in_order(req_i.people);
        end else begin
          predict_elimination(req_i);
        end
      end
    end
  end

  // Presents one request beat after a random gap and holds it until it is taken.
  // Every third run of ten requests goes without gaps.
  task automatic send_request(input jeo_pkg::jeo_req_t rq, input logic in_order);
    int unsigned gap;
    gap = ((requests_sent / 10) % 3 == 2) ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        = 1'b1;
    req_i        = rq;
    req_in_order = in_order;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stimulus: reset, the directed table, then random requests, then drain.
  initial begin : stimulus
    jeo_pkg::jeo_req_t rq;
    int unsigned       pick;
    start         = 1'b0;
    req_i         = '0;
    req_in_order  = 1'b0;
    fault_count   = 0;
    requests_sent = 0;
    rst_ni        = 1'b0;

    // Extremes of both fields, every special case, and a few classic circles.
    stim_rows = '{
      '{7'd1,   10'd0,    1'b1},  // lone person, step of zero
      '{7'd1,   10'd1023, 1'b1},  // lone person, largest step
      '{7'd0,   10'd5,    1'b1},  // empty circle
      '{7'd2,   10'd0,    1'b1},
      '{7'd3,   10'd0,    1'b1},
      '{7'd5,   10'd1,    1'b1},
      '{7'd64,  10'd1,    1'b1},  // full circle, removed in turn
      '{7'd127, 10'd0,    1'b1},  // oversized circle saturates
      '{7'd65,  10'd1,    1'b1},
      '{7'd0,   10'd1023, 1'b1},
      '{7'd2,   10'd2,    1'b0},
      '{7'd5,   10'd2,    1'b0},
      '{7'd7,   10'd3,    1'b0},
      '{7'd41,  10'd3,    1'b0},
      '{7'd64,  10'd2,    1'b0},
      '{7'd127, 10'd3,    1'b0},
      '{7'd3,   10'd512,  1'b0},
      '{7'd4,   10'd1022, 1'b0},
      '{7'd10,  10'd1023, 1'b0},
      '{7'd64,  10'd1023, 1'b0},  // slowest request the fields allow
      '{7'd6,   10'd64,   1'b0},
      '{7'd9,   10'd85,   1'b0}
    };

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      send_request('{people: stim_rows[r].people, step: stim_rows[r].step},
                   stim_rows[r].in_order);
    end

    // Mostly small circles and steps; long steps only on tiny circles so the
    // run stays short; a share of oversized and empty circles.
    for (int r = 0; r < RandomReqs; r++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        rq.people = jeo_pkg::PeopleW'($urandom_range(1, 12));
        rq.step   = jeo_pkg::StepW'($urandom_range(0, 40));
      end else if (pick <= 7) begin
        rq.people = jeo_pkg::PeopleW'($urandom_range(1, 4));
        rq.step   = jeo_pkg::StepW'($urandom_range(0, 1023));
      end else if (pick == 8) begin
        rq.people = jeo_pkg::PeopleW'($urandom_range(13, 127));
        rq.step   = jeo_pkg::StepW'($urandom_range(0, 7));
      end else begin
        rq.people = ($urandom_range(0, 1) == 0) ? '0
                                                : jeo_pkg::PeopleW'($urandom_range(64, 127));
        rq.step   = jeo_pkg::StepW'($urandom_range(0, 3));
      end
      send_request(rq, 1'b0);
    end

    @(negedge clk_i);
    start = 1'b0;

    while (removals_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #600_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
